// File: sv/bgd_pkg.sv
`timescale 1ns / 1ps
package bgd_pkg;

  // Largest number of buttons that an item can address.
  localparam int unsigned MAX_ENTRIES = 8;

  // Item function codes.
  localparam logic [1:0] FUNC_DOWN = 2'd0;
  localparam logic [1:0] FUNC_UP   = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_POLL = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_PRESSED    = 3'd0;
  localparam logic [2:0] KIND_RELEASED   = 3'd1;
  localparam logic [2:0] KIND_HELD       = 3'd2;
  localparam logic [2:0] KIND_TAPPED     = 3'd3;
  localparam logic [2:0] KIND_DOUBLE_TAP = 3'd4;
  localparam logic [2:0] KIND_POLL       = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TAP_WINDOW        = 3'd0;
  localparam logic [2:0] REG_DOUBLE_TAP_WINDOW = 3'd1;
  localparam logic [2:0] REG_DOUBLE_TAP_ENABLE = 3'd2;
  localparam logic [2:0] REG_QUICK_TAP_ENABLE  = 3'd3;
  localparam logic [2:0] REG_QUICK_TAP_BUFFER  = 3'd4;

  // Register reset values.
  localparam logic [15:0] TAP_WINDOW_RESET        = 16'd200;
  localparam logic [15:0] DOUBLE_TAP_WINDOW_RESET = 16'd300;
  localparam logic [15:0] QUICK_TAP_BUFFER_RESET  = 16'd100;

  // Per-event step within one button.
  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_THIRD  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  button;
    logic [31:0] now_time;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  button_index;
    logic [31:0] event_time;
    logic [31:0] duration;
    logic        is_down;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] tap_window;
    logic [15:0] double_tap_window;
    logic        double_tap_enable;
    logic        quick_tap_enable;
    logic [15:0] quick_tap_buffer;
  } cfg_t;

  typedef struct packed {
    logic       take;
    logic       walk;
    logic       emit;
    logic       commit;
    logic [2:0] idx;
    logic [1:0] step;
  } cmd_t;

  typedef struct packed {
    logic edge_here;
    logic final_here;
    logic more_above;
    logic out_free;
  } stat_t;

endpackage

// File: sv/bgd_regs.sv
`timescale 1ns / 1ps
module bgd_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bgd_pkg::cfg_t cfg
);
  import bgd_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_window        <= TAP_WINDOW_RESET;
      cfg.double_tap_window <= DOUBLE_TAP_WINDOW_RESET;
      cfg.double_tap_enable <= 1'b1;
      cfg.quick_tap_enable  <= 1'b1;
      cfg.quick_tap_buffer  <= QUICK_TAP_BUFFER_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_TAP_WINDOW:        cfg.tap_window        <= pwdata[15:0];
        REG_DOUBLE_TAP_WINDOW: cfg.double_tap_window <= pwdata[15:0];
        REG_DOUBLE_TAP_ENABLE: cfg.double_tap_enable <= pwdata[0];
        REG_QUICK_TAP_ENABLE:  cfg.quick_tap_enable  <= pwdata[0];
        REG_QUICK_TAP_BUFFER:  cfg.quick_tap_buffer  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_TAP_WINDOW:        prdata = {16'd0, cfg.tap_window};
      REG_DOUBLE_TAP_WINDOW: prdata = {16'd0, cfg.double_tap_window};
      REG_DOUBLE_TAP_ENABLE: prdata = {31'd0, cfg.double_tap_enable};
      REG_QUICK_TAP_ENABLE:  prdata = {31'd0, cfg.quick_tap_enable};
      REG_QUICK_TAP_BUFFER:  prdata = {16'd0, cfg.quick_tap_buffer};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/bgd_ctrl.sv
`timescale 1ns / 1ps
module bgd_ctrl #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [1:0]     item_func,
  output logic           item_stall,
  input  bgd_pkg::stat_t stat,
  output bgd_pkg::cmd_t  cmd
);
  import bgd_pkg::*;

  localparam int unsigned NUM_ENTRIES = (NUM_BUTTONS < MAX_ENTRIES) ? NUM_BUTTONS : MAX_ENTRIES;
  localparam int unsigned IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  typedef enum logic {IDLE, WALK} state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [1:0]       step;
  logic             idle;
  logic             emit;
  logic             commit;
  logic             advance;

  assign idle       = (state == IDLE);
  assign item_stall = !(idle && stat.out_free);
  assign emit       = !idle && stat.edge_here && stat.out_free;
  assign commit     = emit && stat.final_here;
  // Leave this button once it has nothing left to report: go on to the next changed one or end the scan.
  assign advance    = !idle && (!stat.edge_here || commit);

  always_comb begin
    cmd.take   = item_valid && !item_stall;
    cmd.walk   = !idle;
    cmd.emit   = emit;
    cmd.commit = commit;
    cmd.idx    = 3'(idx);
    cmd.step   = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
      step  <= STEP_FIRST;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.take && item_func == FUNC_TICK) begin
            state <= WALK;
            idx   <= '0;
            step  <= STEP_FIRST;
          end
        end
        WALK: begin
          if (emit && !commit) begin
            step <= step + 2'd1;
          end
          if (advance) begin
            step <= STEP_FIRST;
            if (stat.more_above) begin
              idx <= idx + IDX_W'(1);
            end else begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: sv/bgd_datapath.sv
`timescale 1ns / 1ps
module bgd_datapath #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  bgd_pkg::item_t   item,
  input  bgd_pkg::cfg_t    cfg,
  input  bgd_pkg::cmd_t    cmd,
  output bgd_pkg::stat_t   stat,
  output logic             result_valid,
  input  logic             result_stall,
  output bgd_pkg::result_t result
);
  import bgd_pkg::*;

  localparam int unsigned NUM_ENTRIES = (NUM_BUTTONS < MAX_ENTRIES) ? NUM_BUTTONS : MAX_ENTRIES;
  localparam int unsigned IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [NUM_ENTRIES-1:0] live_down;
  logic [NUM_ENTRIES-1:0] previous_down;
  logic [NUM_ENTRIES-1:0] pressed_since_poll;
  logic [NUM_ENTRIES-1:0] tap_pending;
  logic [31:0]            press_time     [NUM_ENTRIES];
  logic [31:0]            release_time   [NUM_ENTRIES];
  logic [31:0]            tap_start_time [NUM_ENTRIES];
  logic [31:0]            current_time;
  logic                   time_known;

  logic [IDX_W-1:0] rd_idx;
  logic             btn_valid;
  logic             rise;
  logic             fall;
  logic [31:0]      since_start;
  logic [31:0]      dur;
  logic [31:0]      since_release;
  logic             dt_hit;
  logic             tap_hit;
  logic             stretch;
  logic             poll_down;
  logic             more_above;
  logic             final_here;
  logic [2:0]       ev_kind;
  logic [31:0]      ev_dur;
  logic             poll_load;

  assign rd_idx    = cmd.walk ? cmd.idx[IDX_W-1:0] : item.button[IDX_W-1:0];
  assign btn_valid = {29'd0, item.button} < 32'(NUM_BUTTONS);

  assign rise = live_down[rd_idx] && !previous_down[rd_idx];
  assign fall = !live_down[rd_idx] && previous_down[rd_idx];

  assign since_start   = current_time - tap_start_time[rd_idx];
  assign dur           = current_time - press_time[rd_idx];
  assign since_release = current_time - release_time[rd_idx];

  assign dt_hit  = cfg.double_tap_enable && tap_pending[rd_idx]
                   && (current_time >= tap_start_time[rd_idx])
                   && (since_start < {16'd0, cfg.double_tap_window});
  assign tap_hit = dur < {16'd0, cfg.tap_window};
  assign stretch = (current_time >= release_time[rd_idx])
                   && (since_release <= {16'd0, cfg.quick_tap_buffer});

  assign poll_down = btn_valid && (live_down[rd_idx]
                     || (cfg.quick_tap_enable && time_known
                         && pressed_since_poll[rd_idx] && stretch));

  always_comb begin
    more_above = 1'b0;
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      if (IDX_W'(j) > cmd.idx[IDX_W-1:0] && (live_down[j] != previous_down[j])) begin
        more_above = 1'b1;
      end
    end
  end

  // Event order per button: pressed then double tapped on a press; released,
  // held and tapped on a release.
  always_comb begin
    ev_kind    = KIND_PRESSED;
    ev_dur     = 32'd0;
    final_here = 1'b1;
    if (rise) begin
      if (cmd.step == STEP_FIRST) begin
        final_here = !dt_hit;
      end else begin
        ev_kind = KIND_DOUBLE_TAP;
      end
    end else begin
      ev_dur = dur;
      unique case (cmd.step)
        STEP_FIRST: begin
          ev_kind    = KIND_RELEASED;
          final_here = 1'b0;
        end
        STEP_SECOND: begin
          ev_kind    = KIND_HELD;
          final_here = !tap_hit;
        end
        default: ev_kind = KIND_TAPPED;
      endcase
    end
  end

  always_comb begin
    stat.edge_here  = rise || fall;
    stat.final_here = final_here;
    stat.more_above = more_above;
    stat.out_free   = !result_valid || !result_stall;
  end

  assign poll_load = cmd.take && item.func == FUNC_POLL;

  // Button state.
  always_ff @(posedge clk) begin
    if (rst) begin
      live_down          <= '0;
      previous_down      <= '0;
      pressed_since_poll <= '0;
      tap_pending        <= '0;
      current_time       <= 32'd0;
      time_known         <= 1'b0;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        press_time[j]     <= 32'd0;
        release_time[j]   <= 32'd0;
        tap_start_time[j] <= 32'd0;
      end
    end else begin
      if (cmd.take) begin
        unique case (item.func)
          FUNC_DOWN: begin
            if (btn_valid) begin
              live_down[rd_idx]          <= 1'b1;
              pressed_since_poll[rd_idx] <= 1'b1;
            end
          end
          FUNC_UP: begin
            if (btn_valid) begin
              live_down[rd_idx] <= 1'b0;
            end
          end
          FUNC_TICK: begin
            current_time <= item.now_time;
            time_known   <= 1'b1;
          end
          FUNC_POLL: begin
            if (btn_valid) begin
              pressed_since_poll[rd_idx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        previous_down[rd_idx] <= live_down[rd_idx];
        if (rise) begin
          press_time[rd_idx] <= current_time;
          if (cfg.double_tap_enable) begin
            if (dt_hit) begin
              tap_pending[rd_idx]    <= 1'b0;
              tap_start_time[rd_idx] <= 32'd0;
            end else begin
              tap_pending[rd_idx]    <= 1'b1;
              tap_start_time[rd_idx] <= current_time;
            end
          end
        end else begin
          release_time[rd_idx] <= current_time;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit || poll_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.kind         <= ev_kind;
      result.button_index <= cmd.idx;
      result.event_time   <= current_time;
      result.duration     <= ev_dur;
      result.is_down      <= 1'b0;
      result.last         <= final_here && !more_above;
    end else if (poll_load) begin
      result.kind         <= KIND_POLL;
      result.button_index <= item.button;
      result.event_time   <= current_time;
      result.duration     <= 32'd0;
      result.is_down      <= poll_down;
      result.last         <= 1'b1;
    end
  end

endmodule

// File: sv/button_gesture_detector_core.sv
`timescale 1ns / 1ps
// Button gesture detector: tap, double tap and hold events for up to eight buttons.
// Requests arrive on the item channel (item_valid, item_stall, item). A down or up
// request sets or clears a button's live state and produces no result. A tick request
// records the millisecond time and then scans the buttons in index order; a button that
// went down emits pressed and possibly double tapped, one that went up emits released,
// held and possibly tapped. A poll request returns one poll answer.
// Results leave on the result channel (result_valid, result_stall, result); the last
// flag marks the final result of a request. After a tick is taken, the scan stops after
// the highest button that changed. A poll answer is valid from the cycle after
// acceptance. The scan is done by the controller's index counter, so a new request is
// taken only after the previous tick's scan ends. When the receiver stalls, the result
// waits in the output register, the scan pauses on its current event and no new request
// is taken. Reset clears every button's state, the recorded time and restores the
// register defaults (tap window 200, double-tap window 300, both enables on, quick-tap
// buffer 100). Registers are written through the APB-style port; the user must write
// them only while the block is idle, which the block itself does not enforce.
module button_gesture_detector_core #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bgd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bgd_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bgd_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers.
  bgd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller owns the request handshake and the scan position.
  bgd_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_func  (item.func),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the per-button state and the output register.
  bgd_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
